// File: rtl/core/mshd_pkg.sv
// Shared types and constants for the multi-symbol table Huffman decoder.
// No dependencies.
package mshd_pkg;

   localparam int unsigned MAX_RESULTS = 24;   // symbols kept per code-byte beat
   localparam int unsigned FIELD_W     = 12;   // link / next / base width
   localparam int unsigned BUF_W       = 32;   // bit buffer width
   localparam int unsigned CNT_W       = 6;    // bit count width
   localparam int unsigned IDXBITS_W   = 15;   // widest lookup index

   typedef enum logic {
      KIND_TABLE_WRITE = 1'b0,
      KIND_CODE_BYTE   = 1'b1
   } mshd_kind_type;

   // One classified beat as it travels from front end to back end.
   typedef struct packed {
      mshd_kind_type kind;
      logic [11:0]   addr;
      logic [3:0]    count;     // already saturated
      logic [11:0]   link;
      logic [11:0]   next;
      logic [63:0]   syms;
      logic [7:0]    code;      // bits above the valid length cleared
      logic          last;
      logic [3:0]    nbits;     // valid bits carried by code
   } mshd_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mshd_qstat_type;

endpackage

// File: rtl/core/mshd_front.sv
// Front end: accepts request beats, saturates fields and classifies them.
// Depends on mshd_pkg.
module mshd_front #(
   parameter int unsigned SYMS_PER_ENTRY = 8
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [119:0]           req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tuser,
   input  mshd_pkg::mshd_qstat_type q_stat,
   output logic                   q_push,
   output mshd_pkg::mshd_item_type q_item
);

   logic [3:0] cnt_raw;
   logic [3:0] lb_raw;
   logic [3:0] nbits;
   logic [7:0] byte_mask;

   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && !q_stat.full;

   assign cnt_raw = req_tdata[15:12];
   assign lb_raw  = req_tdata[115:112];

   always_comb begin
      if (!req_tlast) begin
         nbits = 4'd8;
      end else if (lb_raw > 4'd8) begin
         nbits = 4'd8;
      end else begin
         nbits = lb_raw;
      end
      byte_mask = 8'((9'd1 << nbits) - 9'd1);
   end

   always_comb begin
      q_item.kind  = req_tuser ? mshd_pkg::KIND_CODE_BYTE : mshd_pkg::KIND_TABLE_WRITE;
      q_item.addr  = req_tdata[11:0];
      q_item.count = (cnt_raw > 4'(SYMS_PER_ENTRY)) ? 4'(SYMS_PER_ENTRY) : cnt_raw;
      q_item.link  = req_tdata[27:16];
      q_item.next  = req_tdata[39:28];
      q_item.syms  = req_tdata[103:40];
      q_item.code  = req_tdata[111:104] & byte_mask;
      q_item.last  = req_tlast;
      q_item.nbits = nbits;
   end

endmodule

// File: rtl/core/mshd_queue.sv
// Two-entry queue between front end and back end.
// Depends on mshd_pkg.
module mshd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mshd_pkg::mshd_item_type push_item,
   input  logic                    pop,
   output mshd_pkg::mshd_item_type pop_item,
   output mshd_pkg::mshd_qstat_type stat
);

   mshd_pkg::mshd_item_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] used_ff, used_in;
   logic       do_push, do_pop;

   assign stat.full  = (used_ff == 2'd2);
   assign stat.empty = (used_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_item   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      used_in = used_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         used_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         used_ff <= used_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/mshd_back.sv
// Back end: table memory, bit buffer, lookup sequencer and output register.
// Depends on mshd_pkg.
module mshd_back #(
   parameter int unsigned ADDR_W         = 12,
   parameter int unsigned SYMS_PER_ENTRY = 8,
   parameter int unsigned MAX_JUMP_BITS  = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               jump_bits,
   input  mshd_pkg::mshd_qstat_type q_stat,
   input  mshd_pkg::mshd_item_type  q_item,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   localparam int unsigned ENTRIES = 1 << ADDR_W;

   typedef struct packed {
      logic [3:0]  count;
      logic [11:0] link;
      logic [11:0] next;
      logic [63:0] syms;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_READ, ST_EMIT, ST_FLUSH
   } state_type;

   entry_type mem [ENTRIES];
   entry_type rd_ff;

   state_type   state_ff;
   logic [mshd_pkg::BUF_W-1:0]   buf_ff, buf_in;
   logic [mshd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [mshd_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [mshd_pkg::FIELD_W-1:0] base_ff;
   logic        last_ff;
   logic [3:0]  k_ff;
   logic [2:0]  sidx_ff;
   logic [4:0]  n_ff;
   logic        pend_ff;
   logic [7:0]  pend_sym_ff;
   logic        out_valid_ff, out_last_ff, out_end_ff;
   logic [7:0]  out_sym_ff;

   logic [3:0]  jb;
   logic [14:0] idx_mask;
   logic [16:0] idx_sum;
   logic [ADDR_W-1:0] idx;
   logic        stop;
   logic [3:0]  k_sat;
   logic [11:0] back_raw;
   logic [3:0]  back;
   logic [3:0]  adv;
   logic        can_load;
   logic        out_load;
   logic        wr_ok;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;
   assign can_load   = !out_valid_ff || rsp_tready;
   assign out_load   = pend_ff && can_load &&
                       (((state_ff == ST_EMIT) && (n_ff < 5'(mshd_pkg::MAX_RESULTS))) ||
                        (state_ff == ST_FLUSH));
   assign q_pop      = (state_ff == ST_IDLE) && !q_stat.empty;
   assign wr_ok      = (17'(q_item.addr) < 17'(ENTRIES));

   always_comb begin
      priority if (jump_bits == 4'd0) begin
         jb = 4'd1;
      end else if (jump_bits > 4'(MAX_JUMP_BITS)) begin
         jb = 4'(MAX_JUMP_BITS);
      end else begin
         jb = jump_bits;
      end
      idx_mask = 15'((16'd1 << jb) - 16'd1);
      idx_sum  = 17'(base_ff) + 17'(buf_ff[14:0] & idx_mask);
      idx      = idx_sum[ADDR_W-1:0];
      stop     = last_ff ? (rem_ff == '0) : (cnt_ff < 6'(jb));
   end

   // Decision on the entry just read: symbols or a step back.
   always_comb begin
      k_sat    = (rd_ff.count > 4'(SYMS_PER_ENTRY)) ? 4'(SYMS_PER_ENTRY) : rd_ff.count;
      back_raw = rd_ff.link;
      back     = (back_raw >= 12'(jb)) ? (jb - 4'd1) : back_raw[3:0];
      adv      = (k_sat != 4'd0) ? jb : (jb - back);
      if (6'(adv) >= cnt_ff) begin
         buf_in = '0;
         cnt_in = '0;
      end else begin
         buf_in = buf_ff >> adv;
         cnt_in = cnt_ff - 6'(adv);
      end
      rem_in = (6'(adv) >= rem_ff) ? '0 : (rem_ff - 6'(adv));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         base_ff      <= '0;
         last_ff      <= 1'b0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  if (q_item.kind == mshd_pkg::KIND_CODE_BYTE) begin
                     buf_ff   <= buf_ff | (32'(q_item.code) << cnt_ff);
                     cnt_ff   <= cnt_ff + 6'(q_item.nbits);
                     rem_ff   <= cnt_ff + 6'(q_item.nbits);
                     last_ff  <= q_item.last;
                     n_ff     <= '0;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               state_ff <= stop ? ST_FLUSH : ST_READ;
            end
            ST_READ: begin
               buf_ff <= buf_in;
               cnt_ff <= cnt_in;
               if (last_ff) begin
                  rem_ff <= rem_in;
               end
               k_ff    <= k_sat;
               sidx_ff <= '0;
               if (k_sat != 4'd0) begin
                  base_ff  <= rd_ff.link;
                  state_ff <= ST_EMIT;
               end else begin
                  base_ff  <= rd_ff.next;
                  state_ff <= ST_CHECK;
               end
            end
            ST_EMIT: begin
               if (!pend_ff || can_load) begin
                  if (n_ff < 5'(mshd_pkg::MAX_RESULTS)) begin
                     if (pend_ff) begin
                        out_sym_ff   <= pend_sym_ff;
                        out_last_ff  <= 1'b0;
                        out_end_ff   <= 1'b0;
                     end
                     pend_ff     <= 1'b1;
                     pend_sym_ff <= rd_ff.syms[{sidx_ff, 3'b000} +: 8];
                     n_ff        <= n_ff + 5'd1;
                  end
                  if (4'(sidx_ff) + 4'd1 == k_ff) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     sidx_ff <= sidx_ff + 3'd1;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_ff || can_load) begin
                  if (pend_ff) begin
                     out_sym_ff   <= pend_sym_ff;
                     out_last_ff  <= 1'b1;
                     out_end_ff   <= last_ff;
                  end
                  pend_ff <= 1'b0;
                  if (last_ff) begin
                     buf_ff  <= '0;
                     cnt_ff  <= '0;
                     rem_ff  <= '0;
                     base_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Table memory: one write port from the queue, one registered read port.
   always_ff @(posedge clock) begin
      if (q_pop && q_item.kind == mshd_pkg::KIND_TABLE_WRITE && wr_ok) begin
         mem[ADDR_W'(q_item.addr)] <= '{count: q_item.count, link: q_item.link,
                                        next: q_item.next, syms: q_item.syms};
      end
      if (state_ff == ST_CHECK) begin
         rd_ff <= mem[idx];
      end
   end

endmodule

// File: rtl/core/multisymbol_table_huffman_decoder_top.sv
// Top level of the multi-symbol table Huffman decoder.
// Depends on mshd_pkg, mshd_front, mshd_queue, mshd_back.
//
//  channel  dir  beat contents
//  -------  ---  -------------------------------------------------------
//  req_     in   tuser kind, tlast final byte, tdata entry / code fields
//  rsp_     out  tdata symbol, tlast last of beat, tuser end of stream
//  csr_     in   jump_bits (4 bits), written when csr_wr_en is high
//
// A table-write beat is written to the table memory as the back end pops it.
// A code-byte beat is merged into the bit buffer; each table lookup then
// reads the memory and decides on the entry read, each symbol of a matched
// entry is emitted in turn, and a final check and a flush close the beat.
// Reset is synchronous; table contents are not cleared by reset.
// The 2-entry queue lets the front take beats while the back end works;
// a stalled rsp_ side holds the back end only when it must emit.
module multisymbol_table_huffman_decoder_top #(
   parameter int unsigned ADDR_W         = 12,  // table holds 2**ADDR_W entries
   parameter int unsigned SYMS_PER_ENTRY = 8,
   parameter int unsigned MAX_JUMP_BITS  = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // low to high: entry_addr[11:0], entry_count[15:12], entry_link[27:16],
   // entry_next[39:28], entry_syms[103:40], code_byte[111:104],
   // last_bits[115:112], zero pad[119:116]
   input  logic [119:0] req_tdata,
   input  logic         req_tlast,   // byte_last
   input  logic         req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // symbol
   output logic         rsp_tlast,   // sym_last
   output logic         rsp_tuser,   // stream_end
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data  // jump_bits
);

   logic [3:0] jump_bits_ff;
   logic       q_push, q_pop;
   mshd_pkg::mshd_item_type  push_item, pop_item;
   mshd_pkg::mshd_qstat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_bits_ff <= 4'd8;
      end else if (csr_wr_en) begin
         jump_bits_ff <= csr_wr_data;
      end
   end

   mshd_front #(.SYMS_PER_ENTRY(SYMS_PER_ENTRY)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   mshd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   mshd_back #(
      .ADDR_W         (ADDR_W),
      .SYMS_PER_ENTRY (SYMS_PER_ENTRY),
      .MAX_JUMP_BITS  (MAX_JUMP_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .jump_bits  (jump_bits_ff),
      .q_stat     (q_stat),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // End-of-stream only ever rides on the closing symbol of a beat.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast))
      else $error("stream end without beat-last");

   // Queue never pushed while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue overflow");

   // Front never offers ready while the queue is full.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_tready)
      else $error("ready while queue full");

endmodule
